// ===== rtl/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, constants and the log table for the roughness penalty block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

    localparam int MAX_LENGTH      = 4096;
    localparam int MAX_ORDER       = 8;
    localparam int LOG_TABLE_DEPTH = 64;
    localparam int FIFO_DEPTH      = 4;

    localparam int IDX_W      = 13;
    localparam int ORDER_W    = 4;
    localparam int CHAIN_W    = 42;
    localparam int LOG_RES_W  = 22;
    localparam int LOG_IDX_W  = $clog2(LOG_TABLE_DEPTH);
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 3;

    localparam logic [35:0] LN2_Q30 = 36'd744261118;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG_MODE      = 3'd0,
        CFG_PENALTY_SCALE = 3'd1,
        CFG_FIRST_INDEX   = 3'd2,
        CFG_LAST_INDEX    = 3'd3,
        CFG_DIFF_ORDER    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        FAULT_OK       = 3'd0,
        FAULT_BOUNDS   = 3'd1,
        FAULT_BEYOND   = 3'd2,
        FAULT_FIRST    = 3'd3,
        FAULT_ORDER    = 3'd4,
        FAULT_LOG      = 3'd5,
        FAULT_TOO_LONG = 3'd6
    } fault_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOG,
        B_CHAIN,
        B_SQ,
        B_ACC,
        B_MUL,
        B_FIN
    } back_state_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_NORM,
        L_LOOK,
        L_MUL,
        L_SUM
    } log_state_t;

    // one classified word handed from front to back
    typedef struct packed {
        logic signed [31:0]   value;
        logic                 win;
        logic                 take_log;
        logic                 nonpos;
        logic                 add_sq;
        logic [ORDER_W-1:0]   depth;
        logic                 last;
        fault_t               code;
    } dsp_item_t;

    typedef logic [31:0] log_rom_t [0:LOG_TABLE_DEPTH];

    // shift-subtract quotient; all table numerators stay below 2^40
    function automatic logic [63:0] div_u40(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [40:0] r;
        q = '0;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            r = {r[39:0], num[b]};
            if (r >= 41'(den)) begin
                r    = r - 41'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/D) in Q2.30 by atanh series, evaluated at elaboration
    function automatic log_rom_t build_log_rom();
        log_rom_t    r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
            z  = div_u40(64'(i) << 30, 64'(2 * LOG_TABLE_DEPTH) + 64'(i));
            z2 = (z * z) >> 30;
            p  = z;
            s  = z;
            for (int k = 3; k <= 41; k += 2) begin
                p = (p * z2) >> 30;
                s = s + div_u40(p, 64'(k));
            end
            r[i] = 32'(s << 1);
        end
        return r;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

// ===== rtl/difference_smoothing_penalty.sv =====
// ----------------------------------------------------------------------------
// difference_smoothing_penalty
// Order-r difference roughness penalty over a streamed Q16.16 vector.
// ----------------------------------------------------------------------------
// The front accepts one word per cycle into a four-entry queue while it is not
// full; the back takes one word at a time. A word outside the window is only
// popped; inside it passes each cascade stage, then a square and an accumulate
// step when a square is added, after the log when the log is taken (five normalize
// steps, table read, interpolation multiply, sum, handoff). The final word adds
// the scaling multiplies and then waits for the result register.
// Configuration must be written only while the block is idle.
`default_nettype none

module difference_smoothing_penalty (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [31:0]   s_sample_value,
    input  wire logic                 s_final_element,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [63:0]        m_penalty_score,
    output logic [2:0]                m_fault_code
);

    logic                                log_mode_reg;
    logic signed [31:0]                  penalty_scale_reg;
    logic [dsp_pkg::IDX_W-1:0]           first_index_reg, last_index_reg;
    logic [dsp_pkg::ORDER_W-1:0]         diff_order_reg;

    logic                 push, pop, fifo_full, fifo_empty;
    dsp_pkg::dsp_item_t   push_item, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_mode_reg      <= 1'b0;
            penalty_scale_reg <= 32'sd65536;
            first_index_reg   <= '0;
            last_index_reg    <= '0;
            diff_order_reg    <= dsp_pkg::ORDER_W'(2);
        end else if (cfg_we) begin
            unique case (dsp_pkg::cfg_index_t'(cfg_index))
                dsp_pkg::CFG_LOG_MODE:      log_mode_reg      <= cfg_data[0];
                dsp_pkg::CFG_PENALTY_SCALE: penalty_scale_reg <= $signed(cfg_data);
                dsp_pkg::CFG_FIRST_INDEX:   first_index_reg   <= cfg_data[dsp_pkg::IDX_W-1:0];
                dsp_pkg::CFG_LAST_INDEX:    last_index_reg    <= cfg_data[dsp_pkg::IDX_W-1:0];
                dsp_pkg::CFG_DIFF_ORDER:    diff_order_reg    <= cfg_data[dsp_pkg::ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    dsp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_final_element (s_final_element),
        .log_mode        (log_mode_reg),
        .first_index     (first_index_reg),
        .last_index      (last_index_reg),
        .diff_order      (diff_order_reg),
        .fifo_full       (fifo_full),
        .push            (push),
        .push_item       (push_item)
    );

    dsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty)
    );

    dsp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fifo_empty      (fifo_empty),
        .head            (head),
        .pop             (pop),
        .penalty_scale   (penalty_scale_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_penalty_score (m_penalty_score),
        .m_fault_code    (m_fault_code)
    );

    // a faulted vector never reports a score
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault_code != dsp_pkg::FAULT_OK) |-> (m_penalty_score == 64'sd0))
        else $error("nonzero score with fault");

    // queue never takes a word while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full |-> !push)
        else $error("push into full queue");

    // back only pops when the queue holds a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/dsp_fifo.sv =====
// ----------------------------------------------------------------------------
// dsp_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire dsp_pkg::dsp_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output dsp_pkg::dsp_item_t      head,
    output logic                    empty
);

    dsp_pkg::dsp_item_t                  mem_reg [0:dsp_pkg::FIFO_DEPTH-1];
    logic [dsp_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [dsp_pkg::FIFO_PTR_W:0]        count_reg;

    assign full  = (count_reg == (dsp_pkg::FIFO_PTR_W+1)'(dsp_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsp_front.sv =====
// ----------------------------------------------------------------------------
// dsp_front
// Counts elements, decides window membership and builds the fault code.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [31:0]            s_sample_value,
    input  wire logic                          s_final_element,
    input  wire logic                          log_mode,
    input  wire logic [dsp_pkg::IDX_W-1:0]     first_index,
    input  wire logic [dsp_pkg::IDX_W-1:0]     last_index,
    input  wire logic [dsp_pkg::ORDER_W-1:0]   diff_order,
    input  wire logic                          fifo_full,
    output logic                               push,
    output dsp_pkg::dsp_item_t                 push_item
);

    localparam logic [dsp_pkg::IDX_W-1:0] MAX_LEN = dsp_pkg::IDX_W'(dsp_pkg::MAX_LENGTH);
    localparam logic [dsp_pkg::ORDER_W-1:0] MAX_ORD = dsp_pkg::ORDER_W'(dsp_pkg::MAX_ORDER);

    logic [dsp_pkg::IDX_W-1:0]   count_reg;
    logic                        log_fault_reg;

    logic                        whole;
    logic [dsp_pkg::IDX_W-1:0]   lo, hi, n;
    logic [dsp_pkg::ORDER_W-1:0] depth;
    logic                        win, nonpos, take_log, fault_next;
    dsp_pkg::fault_t             code;

    always_comb begin
        whole      = (first_index == '0) && (last_index == '0);
        lo         = whole ? dsp_pkg::IDX_W'(1) : first_index;
        depth      = (diff_order > MAX_ORD) ? MAX_ORD : diff_order;
        n          = (count_reg <= MAX_LEN) ? count_reg + 1'b1 : count_reg;
        win        = (n <= MAX_LEN) && (n >= lo) && (whole || n <= last_index);
        nonpos     = (s_sample_value <= 0);
        take_log   = log_mode && win;
        fault_next = log_fault_reg || (take_log && nonpos);
        hi         = whole ? n : last_index;

        if (n > MAX_LEN)                                    code = dsp_pkg::FAULT_TOO_LONG;
        else if (hi <= lo)                                  code = dsp_pkg::FAULT_BOUNDS;
        else if (hi > n)                                    code = dsp_pkg::FAULT_BEYOND;
        else if (lo == '0)                                  code = dsp_pkg::FAULT_FIRST;
        else if (diff_order > MAX_ORD ||
                 dsp_pkg::IDX_W'(diff_order) >= hi - lo)    code = dsp_pkg::FAULT_ORDER;
        else if (fault_next)                                code = dsp_pkg::FAULT_LOG;
        else                                                code = dsp_pkg::FAULT_OK;

        push_item.value    = s_sample_value;
        push_item.win      = win;
        push_item.take_log = take_log;
        push_item.nonpos   = nonpos;
        push_item.add_sq   = (n - lo) >= dsp_pkg::IDX_W'(depth);
        push_item.depth    = depth;
        push_item.last     = s_final_element;
        push_item.code     = code;
    end

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            log_fault_reg <= 1'b0;
        end else if (push) begin
            if (s_final_element) begin
                count_reg     <= '0;
                log_fault_reg <= 1'b0;
            end else begin
                count_reg     <= n;
                log_fault_reg <= fault_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsp_log.sv =====
// ----------------------------------------------------------------------------
// dsp_log
// Multi-cycle natural log of a positive Q16.16 value, result in signed Q6.16.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_log (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [30:0]                          x,
    output logic                                      done,
    output logic signed [dsp_pkg::LOG_RES_W-1:0]      result
);

    dsp_pkg::log_state_t state_reg, state_next;

    logic [30:0]                        xr_reg;
    logic [4:0]                         m_reg;
    logic [2:0]                         step_reg;
    logic [31:0]                        lo_reg, diff_reg;
    logic [29:0]                        rem_reg;
    logic signed [35:0]                 base_reg;
    logic [61:0]                        prod_reg;
    logic signed [dsp_pkg::LOG_RES_W-1:0] result_reg;
    logic                               done_reg;

    logic [4:0]                         sh;
    logic                               top_zero;
    logic [dsp_pkg::LOG_IDX_W-1:0]      idx;
    logic signed [6:0]                  m_exp;
    logic signed [35:0]                 v_sum, v_rnd;

    always_comb begin
        sh       = 5'd16 >> step_reg;
        top_zero = ((xr_reg >> (5'd31 - sh)) == '0);
        idx      = xr_reg[29 -: dsp_pkg::LOG_IDX_W];
        m_exp    = $signed({2'b00, m_reg}) - 7'sd16;
        v_sum    = base_reg + $signed(36'(lo_reg)) + $signed(36'(prod_reg[61:30]));
        v_rnd    = v_sum + 36'sd8192;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsp_pkg::L_IDLE: if (start) state_next = dsp_pkg::L_NORM;
            dsp_pkg::L_NORM: if (step_reg == 3'd4) state_next = dsp_pkg::L_LOOK;
            dsp_pkg::L_LOOK: state_next = dsp_pkg::L_MUL;
            dsp_pkg::L_MUL:  state_next = dsp_pkg::L_SUM;
            dsp_pkg::L_SUM:  state_next = dsp_pkg::L_IDLE;
            default:         state_next = dsp_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsp_pkg::L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == dsp_pkg::L_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            dsp_pkg::L_IDLE: begin
                xr_reg   <= x;
                m_reg    <= 5'd30;
                step_reg <= '0;
            end
            dsp_pkg::L_NORM: begin
                // binary search for the leading one: shifts of 16, 8, 4, 2, 1
                if (top_zero) begin
                    xr_reg <= xr_reg << sh;
                    m_reg  <= m_reg - sh;
                end
                step_reg <= step_reg + 1'b1;
            end
            dsp_pkg::L_LOOK: begin
                lo_reg   <= dsp_pkg::LOG_ROM[idx];
                diff_reg <= dsp_pkg::LOG_ROM[(dsp_pkg::LOG_IDX_W+1)'(idx) + 1'b1]
                            - dsp_pkg::LOG_ROM[idx];
                rem_reg  <= {xr_reg[29-dsp_pkg::LOG_IDX_W:0], dsp_pkg::LOG_IDX_W'(0)};
                base_reg <= 36'(36'(m_exp) * $signed(dsp_pkg::LN2_Q30));
            end
            dsp_pkg::L_MUL: begin
                prod_reg <= 62'(diff_reg) * 62'(rem_reg);
            end
            dsp_pkg::L_SUM: begin
                result_reg <= v_rnd[35:14];
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/dsp_back.sv =====
// ----------------------------------------------------------------------------
// dsp_back
// Optional log, difference cascade, square accumulation and final scaling with result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fifo_empty,
    input  wire dsp_pkg::dsp_item_t    head,
    output logic                       pop,
    input  wire logic signed [31:0]    penalty_scale,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [63:0]         m_penalty_score,
    output logic [2:0]                 m_fault_code
);

    localparam int CW = dsp_pkg::CHAIN_W;

    dsp_pkg::back_state_t state_reg, state_next;
    dsp_pkg::dsp_item_t   item_reg;

    logic signed [CW-1:0]          chain_reg [0:dsp_pkg::MAX_ORDER];
    logic signed [CW-1:0]          v_reg, prev_reg;
    logic [dsp_pkg::ORDER_W-1:0]   k_reg;
    logic [63:0]                   sq_reg, sum_reg, ph_reg, pl_reg;
    logic                          m_valid_reg, m_valid_next;
    logic signed [63:0]            score_reg;
    logic [2:0]                    code_reg;

    logic                          log_start, log_done;
    logic signed [dsp_pkg::LOG_RES_W-1:0] log_result;
    logic signed [CW-1:0]          new_diff;
    logic [CW-1:0]                 mag_d;
    logic                          neg;
    logic [31:0]                   a_scale;
    logic [63:0]                   mag, sum_add;
    logic                          sum_ovf;
    logic signed [63:0]            score;
    logic                          out_free;

    dsp_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (head.value[30:0]),
        .done    (log_done),
        .result  (log_result)
    );

    always_comb begin
        new_diff = prev_reg - chain_reg[k_reg];
        mag_d    = prev_reg[CW-1] ? CW'(-prev_reg) : CW'(prev_reg);
        {sum_ovf, sum_add} = 65'(sum_reg) + 65'(sq_reg);
        neg      = penalty_scale[31];
        a_scale  = neg ? 32'(-penalty_scale) : 32'(penalty_scale);
        mag      = (ph_reg >= 64'h0000_8000_0000_0000) ? '1
                 : (ph_reg << 16) + (pl_reg >> 16);
        if (neg) begin
            score = (mag > 64'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
                                                    : $signed(64'd0 - mag);
        end else begin
            score = (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                    : $signed(mag);
        end
        out_free     = !m_valid_reg || m_ready;
        m_valid_next = ((state_reg == dsp_pkg::B_FIN) && out_free)
                     || (m_valid_reg && !m_ready);
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        log_start  = 1'b0;
        unique case (state_reg)
            dsp_pkg::B_IDLE: begin
                if (!fifo_empty) begin
                    pop = 1'b1;
                    if (head.win) begin
                        if (head.take_log && !head.nonpos) begin
                            log_start  = 1'b1;
                            state_next = dsp_pkg::B_LOG;
                        end else begin
                            state_next = dsp_pkg::B_CHAIN;
                        end
                    end else if (head.last) begin
                        state_next = dsp_pkg::B_MUL;
                    end
                end
            end
            dsp_pkg::B_LOG: if (log_done) state_next = dsp_pkg::B_CHAIN;
            dsp_pkg::B_CHAIN: begin
                if (k_reg == item_reg.depth) begin
                    if (item_reg.add_sq)    state_next = dsp_pkg::B_SQ;
                    else if (item_reg.last) state_next = dsp_pkg::B_MUL;
                    else                    state_next = dsp_pkg::B_IDLE;
                end
            end
            dsp_pkg::B_SQ:  state_next = dsp_pkg::B_ACC;
            dsp_pkg::B_ACC: state_next = item_reg.last ? dsp_pkg::B_MUL : dsp_pkg::B_IDLE;
            dsp_pkg::B_MUL: state_next = dsp_pkg::B_FIN;
            dsp_pkg::B_FIN: if (out_free) state_next = dsp_pkg::B_IDLE;
            default:        state_next = dsp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dsp_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
            sum_reg     <= '0;
            for (int i = 0; i <= dsp_pkg::MAX_ORDER; i++) chain_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            case (state_reg)
                dsp_pkg::B_CHAIN: begin
                    if (k_reg == '0) chain_reg[k_reg] <= v_reg;
                    else             chain_reg[k_reg] <= new_diff;
                end
                dsp_pkg::B_ACC: sum_reg <= sum_ovf ? '1 : sum_add;
                dsp_pkg::B_FIN: begin
                    if (out_free) begin
                        sum_reg     <= '0;
                        for (int i = 0; i <= dsp_pkg::MAX_ORDER; i++) chain_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            dsp_pkg::B_IDLE: begin
                item_reg <= head;
                k_reg    <= '0;
                v_reg    <= head.take_log ? '0 : CW'(head.value);
            end
            dsp_pkg::B_LOG: if (log_done) v_reg <= CW'(log_result);
            dsp_pkg::B_CHAIN: begin
                prev_reg <= (k_reg == '0) ? v_reg : new_diff;
                k_reg    <= k_reg + 1'b1;
            end
            dsp_pkg::B_SQ: begin
                sq_reg <= (mag_d[CW-1:32] != '0) ? '1 : 64'(mag_d[31:0]) * 64'(mag_d[31:0]);
            end
            dsp_pkg::B_MUL: begin
                ph_reg <= 64'(sum_reg[63:32]) * 64'(a_scale);
                pl_reg <= 64'(sum_reg[31:0]) * 64'(a_scale);
            end
            dsp_pkg::B_FIN: begin
                if (out_free) begin
                    score_reg <= (item_reg.code == dsp_pkg::FAULT_OK) ? score : '0;
                    code_reg  <= item_reg.code;
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_penalty_score = score_reg;
    assign m_fault_code    = code_reg;

endmodule

`default_nettype wire

// ===== tb/tb_difference_smoothing_penalty.sv =====
// ----------------------------------------------------------------------------
// tb_difference_smoothing_penalty
// Self-checking bench for the order-r difference roughness penalty block.
// Words are streamed in, a cycle-free model predicts the score and fault of
// each vector, and every result word is compared against the oldest prediction.
// The bench runs directed cases first, then random vectors under three
// idle patterns, and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_difference_smoothing_penalty;
    import dsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        longint score;
        fault_t code;
    } penalty_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [31:0]   s_sample_value;
    logic                 s_final_element;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [63:0]   m_penalty_score;
    logic [2:0]           m_fault_code;

    difference_smoothing_penalty dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_final_element (s_final_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_penalty_score (m_penalty_score),
        .m_fault_code    (m_fault_code)
    );

    // model copy of configuration
    logic              mdl_log_mode;
    longint            mdl_scale;
    logic [IDX_W-1:0]  mdl_first;
    logic [IDX_W-1:0]  mdl_last;
    logic [3:0]        mdl_order;

    // model copy of vector state
    int unsigned       mdl_count;
    longint            mdl_chain [0:MAX_ORDER];
    logic [63:0]       mdl_sum;
    logic              mdl_log_bad;

    logic [31:0]       ln_table [0:LOG_TABLE_DEPTH];

    penalty_t          pending_scores [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int mismatches;
    int words_sent;
    int vectors_sent;
    int results_seen;
    int fault_hits [0:7];
    int stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------ model

    function automatic void build_ln_table();
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
            z  = (64'(i) << 30) / (64'(2 * LOG_TABLE_DEPTH) + 64'(i));
            z2 = (z * z) >> 30;
            p  = z;
            s  = z;
            for (int k = 3; k <= 41; k += 2) begin
                p = (p * z2) >> 30;
                s = s + p / 64'(k);
            end
            ln_table[i] = 32'(2 * s);
        end
    endfunction

    function automatic longint ln_q16(logic [63:0] x);
        int          m;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] interp;
        longint      v;
        m = 30;
        while (m > 0 && x[m] == 1'b0) m--;
        f      = (x << (30 - m)) & 64'h3FFF_FFFF;
        t      = f * 64'(LOG_TABLE_DEPTH);
        idx    = t >> 30;
        rem    = t & 64'h3FFF_FFFF;
        interp = 64'(ln_table[idx]) +
                 (((64'(ln_table[idx + 1]) - 64'(ln_table[idx])) * rem) >> 30);
        v = longint'(m - 16) * longint'(LN2_Q30) + longint'(interp);
        return (v + 8192) >>> 14;
    endfunction

    function automatic void clear_vector();
        mdl_count   = 0;
        mdl_sum     = '0;
        mdl_log_bad = 1'b0;
        for (int k = 0; k <= MAX_ORDER; k++) mdl_chain[k] = 0;
    endfunction

    function automatic longint scale_sum();
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] a;
        logic [63:0] ph;
        logic [63:0] mag;
        hi  = mdl_sum >> 32;
        lo  = mdl_sum & 64'hFFFF_FFFF;
        a   = (mdl_scale < 0) ? 64'(-mdl_scale) : 64'(mdl_scale);
        ph  = hi * a;
        if (ph >= (64'd1 << 47)) mag = '1;
        else mag = (ph << 16) + ((lo * a) >> 16);
        if (mdl_scale < 0) begin
            if (mag > (64'd1 << 63)) mag = 64'd1 << 63;
            return longint'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF_FFFF_FFFF) mag = 64'h7FFF_FFFF_FFFF_FFFF;
        return longint'(mag);
    endfunction

    // advance the model by one accepted word; true when a result is due
    function automatic bit predict_word(logic signed [31:0] value, logic fin,
                                        output penalty_t res);
        bit          whole;
        int unsigned lo;
        int unsigned hi;
        int unsigned depth;
        int unsigned n;
        longint      v;
        longint      prev;
        longint      old;
        longint      d;
        logic [63:0] a;
        logic [63:0] sq;
        fault_t      code;
        whole = (mdl_first == 0 && mdl_last == 0);
        lo    = whole ? 1 : mdl_first;
        depth = (mdl_order > MAX_ORDER) ? MAX_ORDER : mdl_order;
        if (mdl_count <= MAX_LENGTH) mdl_count++;
        n = mdl_count;
        if (n <= MAX_LENGTH && n >= lo && (whole || n <= mdl_last)) begin
            v    = longint'(value);
            prev = 0;
            if (mdl_log_mode) begin
                if (v <= 0) begin
                    mdl_log_bad = 1'b1;
                    v = 0;
                end else begin
                    v = ln_q16(64'(v));
                end
            end
            for (int k = 0; k <= depth; k++) begin
                old = mdl_chain[k];
                mdl_chain[k] = (k == 0) ? v : prev - old;
                prev = mdl_chain[k];
            end
            if (n - lo >= depth) begin
                d  = mdl_chain[depth];
                a  = (d < 0) ? 64'(-d) : 64'(d);
                sq = (a >= (64'd1 << 32)) ? '1 : a * a;
                mdl_sum = (mdl_sum > ~sq) ? '1 : mdl_sum + sq;
            end
        end
        if (!fin) return 0;
        hi = whole ? n : mdl_last;
        if (n > MAX_LENGTH) code = FAULT_TOO_LONG;
        else if (hi <= lo) code = FAULT_BOUNDS;
        else if (hi > n) code = FAULT_BEYOND;
        else if (lo < 1) code = FAULT_FIRST;
        else if (mdl_order > MAX_ORDER || mdl_order >= hi - lo) code = FAULT_ORDER;
        else if (mdl_log_bad) code = FAULT_LOG;
        else code = FAULT_OK;
        res.code  = code;
        res.score = (code == FAULT_OK) ? scale_sum() : 0;
        clear_vector();
        return 1;
    endfunction

    // --------------------------------------------------------------- drivers

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_LOG_MODE:      mdl_log_mode = data[0];
            CFG_PENALTY_SCALE: mdl_scale = longint'(signed'(data));
            CFG_FIRST_INDEX:   mdl_first = data[IDX_W-1:0];
            CFG_LAST_INDEX:    mdl_last = data[IDX_W-1:0];
            CFG_DIFF_ORDER:    mdl_order = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic lm, logic [31:0] scale, int first, int last,
                              int order);
        write_reg(CFG_LOG_MODE, 32'(lm));
        write_reg(CFG_PENALTY_SCALE, scale);
        write_reg(CFG_FIRST_INDEX, 32'(first));
        write_reg(CFG_LAST_INDEX, 32'(last));
        write_reg(CFG_DIFF_ORDER, 32'(order));
        cfg_we <= 1'b0;
    endtask

    // wait until every result is in, then let the back end settle
    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (pending_scores.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_word(logic signed [31:0] value, logic fin);
        penalty_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_sample_value  <= value;
        s_final_element <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (predict_word(value, fin, res)) begin
            pending_scores = {pending_scores, res};
            vectors_sent++;
        end
    endtask

    function automatic logic [31:0] rand_value(bit positive);
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'($urandom_range(200000)) - 32'd100000;
            3: v = 32'($urandom_range(4)) << 16;
            default: v = $urandom;
        endcase
        if (positive) begin
            v[31] = 1'b0;
            if (v == 0) v = 32'd1;
        end
        return v;
    endfunction

    task automatic send_vector(int len, bit positive);
        for (int i = 1; i <= len; i++) send_word(rand_value(positive), i == len);
    endtask

    // ----------------------------------------------------------------- tests

    task automatic test_default_config();
        send_word(32'sd65536, 1'b0);
        send_word(32'sd131072, 1'b0);
        send_word(32'sd65536, 1'b0);
        send_word(-32'sd65536, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        drain();
    endtask

    task automatic test_faults();
        set_config(1'b0, 32'h0001_0000, 3, 3, 1);       // bounds equal
        send_vector(4, 0);
        drain();
        set_config(1'b0, 32'h0001_0000, 2, 9, 1);       // last past length
        send_vector(4, 0);
        drain();
        set_config(1'b0, 32'h0001_0000, 0, 5, 1);       // first below one
        send_vector(5, 0);
        drain();
        set_config(1'b0, 32'h0001_0000, 0, 0, 15);      // order too large
        send_vector(3, 0);
        drain();
        set_config(1'b1, 32'h0001_0000, 0, 0, 1);       // log of nonpositive
        send_word(32'sd65536, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(32'sd3, 1'b1);
        drain();
        // negative outside window: no log fault
        set_config(1'b1, 32'h8000_0000, 2, 4, 1);
        send_word(-32'sd5, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'sd65536, 1'b1);
        drain();
        set_config(1'b0, 32'h7FFF_FFFF, 0, 0, 0);
        send_vector(2, 0);
        drain();
    endtask

    task automatic random_config(output int len, output bit positive);
        int          first;
        int          last;
        int          order;
        logic [31:0] scale;
        logic        lm;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        lm  = ($urandom_range(3) == 0);
        case ($urandom_range(4))
            0: scale = 32'h8000_0000;
            1: scale = 32'h7FFF_FFFF;
            2: scale = 32'($urandom_range(131072)) - 32'd65536;
            default: scale = $urandom;
        endcase
        case ($urandom_range(5))
            0, 1: begin
                first = 0;
                last  = 0;
            end
            2: begin
                first = $urandom_range(15);
                last  = $urandom_range(15);
            end
            3: begin
                first = $urandom;
                last  = $urandom;
            end
            default: begin
                first = (len > 1) ? $urandom_range(1, len - 1) : 1;
                last  = (len > 1) ? $urandom_range(first + 1, len) : 2;
            end
        endcase
        order    = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(3);
        positive = lm && ($urandom_range(4) != 0);
        set_config(lm, scale, first & 16'h1FFF, last & 16'h1FFF, order);
    endtask

    task automatic test_random(int words);
        int len;
        bit positive;
        int stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            random_config(len, positive);
            repeat (4) send_vector(len, positive);
            drain();
        end
    endtask

    task automatic test_output_stall();
        int len;
        bit positive;
        hold_request = 400;
        set_config(1'b0, 32'h0001_0000, 0, 0, 1);
        for (int v = 0; v < 8; v++) send_vector(3, 0);
        drain();
        random_config(len, positive);
        drain();
    endtask

    // ------------------------------------------------------- result checking

    always @(posedge aclk) begin
        penalty_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            fault_hits[m_fault_code]++;
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result score=%0d fault=%0d",
                             m_penalty_score, m_fault_code);
            end else begin
                want = pending_scores.pop_front();
                if (m_penalty_score !== want.score || m_fault_code !== want.code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp score=%0d fault=%0d got score=%0d fault=%0d",
                                 results_seen, want.score, want.code,
                                 m_penalty_score, m_fault_code);
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // count cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_sample_value  = '0;
        s_final_element = 1'b0;
        m_ready         = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_request    = 0;
        hold_left       = 0;
        mismatches      = 0;
        words_sent      = 0;
        vectors_sent    = 0;
        results_seen    = 0;
        stall_cycles    = 0;
        foreach (fault_hits[i]) fault_hits[i] = 0;
        build_ln_table();
        mdl_log_mode = 1'b0;
        mdl_scale    = 65536;
        mdl_first    = '0;
        mdl_last     = '0;
        mdl_order    = 4'd2;
        clear_vector();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 37;
        recv_idle_pct = 72;
        test_default_config();
        test_faults();
        test_random(450);
        send_idle_pct = 72;
        recv_idle_pct = 37;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        test_output_stall();

        drain();
        if (pending_scores.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", pending_scores.size());
        end
        $display("Covered %0d words in %0d vectors, %0d results checked, %0d mismatches",
                 words_sent, vectors_sent, results_seen, mismatches);
        $display("Fault codes seen: ok=%0d bounds=%0d beyond=%0d first=%0d order=%0d log=%0d long=%0d",
                 fault_hits[0], fault_hits[1], fault_hits[2], fault_hits[3],
                 fault_hits[4], fault_hits[5], fault_hits[6]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
